>>> rtl/core/dcbl_pkg.sv
// types and constants shared by the dma channel sequencer modules
package dcbl_pkg;

	// input item
	typedef struct packed {
		logic        operation;
		logic [31:0] data_word;
	} item_t;

	// result item
	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] address;
		logic [31:0] data_out;
		logic        raise_irq;
		logic        last;
	} result_t;

	// channel configuration
	typedef struct packed {
		logic [23:0] base_address;
		logic [23:0] word_count;
		logic        step_down;
		logic        to_ram;
		logic        list_mode;
		logic        table_clear;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        is_start;
		logic [7:0]  hdr_count;
		logic [23:0] hdr_next;
		logic [31:0] word;
	} cmd_t;

	// operation codes
	localparam logic OP_START = 1'b0;

	// result kinds
	localparam logic [2:0] KIND_READ   = 3'd0;
	localparam logic [2:0] KIND_WRITE  = 3'd1;
	localparam logic [2:0] KIND_DEVICE = 3'd2;
	localparam logic [2:0] KIND_DONE   = 3'd3;
	localparam logic [2:0] KIND_ERROR  = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_BASE_ADDRESS = 3'd0;
	localparam logic [2:0] CFG_WORD_COUNT   = 3'd1;
	localparam logic [2:0] CFG_STEP_DOWN    = 3'd2;
	localparam logic [2:0] CFG_TO_RAM       = 3'd3;
	localparam logic [2:0] CFG_LIST_MODE    = 3'd4;
	localparam logic [2:0] CFG_TABLE_CLEAR  = 3'd5;

	// list end marker
	localparam logic [23:0] END_MARKER = 24'hFFFFFF;

endpackage

>>> rtl/core/dcbl_front.sv
// front end: accepts items, splits header fields and queues commands for the back end
module dcbl_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  dcbl_pkg::item_t item,
	output logic          cmd_valid,
	output dcbl_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import dcbl_pkg::*;

	localparam int Depth = 2;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] count_q;
	cmd_t            cls;
	logic            do_push;
	logic            do_pop;

	// classify the incoming beat
	always_comb begin
		cls.is_start  = (item.operation == OP_START);
		cls.hdr_count = item.data_word[31:24];
		cls.hdr_next  = item.data_word[23:0];
		cls.word      = item.data_word;
	end

	assign full      = (count_q == CntW'(Depth));
	assign cmd_valid = (count_q != '0);
	assign cmd       = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	// command storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= cls;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= PtrW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= PtrW'(rd_q + 1'b1);
			end
			count_q <= CntW'(count_q + CntW'(do_push) - CntW'(do_pop));
		end
	end

endmodule

>>> rtl/core/dcbl_exec.sv
// back end: channel sequencer that turns commands into up to two results
module dcbl_exec #(
	parameter int RAM_ADDR_BITS = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dcbl_pkg::cfg_t    cfg,
	input  logic              cmd_valid,
	input  dcbl_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  logic              room,
	output dcbl_pkg::result_t res0,
	output dcbl_pkg::result_t res1,
	output logic [1:0]        res_count
);
	import dcbl_pkg::*;

	localparam logic [23:0] RamMask     = 24'((32'd1 << RAM_ADDR_BITS) - 32'd1);
	localparam logic [23:0] RamWordMask = RamMask & ~24'd3;

	typedef enum logic [2:0] {
		IDLE,
		BLOCK_READ,
		BLOCK_WRITE,
		LIST_HEADER,
		LIST_PACKET
	} phase_t;

	phase_t      phase_q,  phase_d;
	logic [23:0] cur_q,    cur_d;
	logic [23:0] wl_q,     wl_d;
	logic [7:0]  pl_q,     pl_d;
	logic [23:0] np_q,     np_d;

	logic        go;
	logic [23:0] stepped;
	logic [23:0] plus4;
	logic [23:0] wl_dec;
	logic [7:0]  pl_dec;
	logic [23:0] follow_ptr;
	result_t     follow_res;
	phase_t      follow_phase;
	logic [31:0] write_word;

	assign go      = cmd_valid && room;
	assign cmd_pop = go;
	assign stepped = cfg.step_down ? (cur_q - 24'd4) : (cur_q + 24'd4);
	assign plus4   = cur_q + 24'd4;
	assign wl_dec  = wl_q - 24'd1;
	assign pl_dec  = pl_q - 8'd1;

	// end of a packet: follow the next pointer or finish the walk
	always_comb begin
		follow_ptr = (phase_q == LIST_HEADER) ? cmd.hdr_next : np_q;
		follow_res = '0;
		follow_res.last = 1'b1;
		if (follow_ptr[23]) begin
			follow_res.kind      = KIND_DONE;
			follow_res.address   = follow_ptr;
			follow_res.raise_irq = (follow_ptr != END_MARKER);
			follow_phase         = IDLE;
		end else begin
			follow_res.kind    = KIND_READ;
			follow_res.address = follow_ptr & RamWordMask;
			follow_phase       = LIST_HEADER;
		end
	end

	// word written to ram: generated table entry or device word
	always_comb begin
		if (!cfg.table_clear) begin
			write_word = cmd.word;
		end else if (wl_q == 24'd1) begin
			write_word = {8'd0, END_MARKER};
		end else begin
			write_word = {8'd0, (cur_q - 24'd4) & RamMask};
		end
	end

	// sequencer next state and results
	always_comb begin
		phase_d   = phase_q;
		cur_d     = cur_q;
		wl_d      = wl_q;
		pl_d      = pl_q;
		np_d      = np_q;
		res0      = '0;
		res1      = '0;
		res_count = 2'd0;
		if (go) begin
			if (cmd.is_start) begin
				cur_d     = cfg.base_address;
				pl_d      = 8'd0;
				np_d      = 24'd0;
				res0.last = 1'b1;
				if (cfg.list_mode) begin
					wl_d      = 24'd0;
					res_count = 2'd1;
					if (cfg.to_ram) begin
						res0.kind    = KIND_ERROR;
						res0.address = cfg.base_address;
						phase_d      = IDLE;
					end else begin
						res0.kind    = KIND_READ;
						res0.address = cfg.base_address & RamWordMask;
						phase_d      = LIST_HEADER;
					end
				end else begin
					wl_d = cfg.word_count;
					if (cfg.word_count == 24'd0) begin
						res0.kind    = KIND_DONE;
						res0.address = cfg.base_address;
						res_count    = 2'd1;
						phase_d      = IDLE;
					end else if (cfg.to_ram) begin
						phase_d = BLOCK_WRITE;
					end else begin
						res0.kind    = KIND_READ;
						res0.address = cfg.base_address & RamWordMask;
						res_count    = 2'd1;
						phase_d      = BLOCK_READ;
					end
				end
			end else begin
				unique case (phase_q)
					BLOCK_READ: begin
						res0.kind     = KIND_DEVICE;
						res0.data_out = cmd.word;
						res1.last     = 1'b1;
						res_count     = 2'd2;
						cur_d         = stepped;
						wl_d          = wl_dec;
						if (wl_dec == 24'd0) begin
							res1.kind    = KIND_DONE;
							res1.address = stepped;
							phase_d      = IDLE;
						end else begin
							res1.kind    = KIND_READ;
							res1.address = stepped & RamWordMask;
						end
					end
					BLOCK_WRITE: begin
						res0.kind     = KIND_WRITE;
						res0.address  = cur_q & RamWordMask;
						res0.data_out = write_word;
						cur_d         = stepped;
						wl_d          = wl_dec;
						if (wl_dec == 24'd0) begin
							res1.kind    = KIND_DONE;
							res1.address = stepped;
							res1.last    = 1'b1;
							res_count    = 2'd2;
							phase_d      = IDLE;
						end else begin
							res0.last = 1'b1;
							res_count = 2'd1;
						end
					end
					LIST_HEADER: begin
						pl_d      = cmd.hdr_count;
						np_d      = cmd.hdr_next;
						res_count = 2'd1;
						if (cmd.hdr_count == 8'd0) begin
							cur_d   = follow_ptr;
							res0    = follow_res;
							phase_d = follow_phase;
						end else begin
							cur_d        = plus4;
							res0.kind    = KIND_READ;
							res0.address = plus4 & RamWordMask;
							res0.last    = 1'b1;
							phase_d      = LIST_PACKET;
						end
					end
					LIST_PACKET: begin
						res0.kind     = KIND_DEVICE;
						res0.data_out = cmd.word;
						res_count     = 2'd2;
						pl_d          = pl_dec;
						if (pl_dec == 8'd0) begin
							cur_d   = follow_ptr;
							res1    = follow_res;
							phase_d = follow_phase;
						end else begin
							cur_d        = plus4;
							res1.kind    = KIND_READ;
							res1.address = plus4 & RamWordMask;
							res1.last    = 1'b1;
						end
					end
					default: begin
						phase_d = IDLE;
					end
				endcase
			end
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= IDLE;
			cur_q   <= '0;
			wl_q    <= '0;
			pl_q    <= '0;
			np_q    <= '0;
		end else begin
			phase_q <= phase_d;
			cur_q   <= cur_d;
			wl_q    <= wl_d;
			pl_q    <= pl_d;
			np_q    <= np_d;
		end
	end

endmodule

>>> rtl/core/dcbl_outq.sv
// result queue: takes up to two results a cycle, hands out one
module dcbl_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  dcbl_pkg::result_t wr0,
	input  dcbl_pkg::result_t wr1,
	input  logic [1:0]        wr_count,
	output logic              room,
	output logic              empty,
	input  logic              pop,
	output dcbl_pkg::result_t head
);
	import dcbl_pkg::*;

	localparam int Depth = 4;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	result_t         mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] count_q;
	logic [PtrW-1:0] wr_next;
	logic            do_pop;

	assign wr_next = PtrW'(wr_q + 1'b1);
	assign room    = (count_q <= CntW'(Depth - 2));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_q];
	assign do_pop  = pop && !empty;

	// result storage
	always_ff @(posedge clk) begin
		if (wr_count != 2'd0) begin
			mem_q[wr_q] <= wr0;
		end
		if (wr_count == 2'd2) begin
			mem_q[wr_next] <= wr1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q <= PtrW'(wr_q + PtrW'(wr_count));
			if (do_pop) begin
				rd_q <= PtrW'(rd_q + 1'b1);
			end
			count_q <= CntW'(count_q + CntW'(wr_count) - CntW'(do_pop));
		end
	end

endmodule

>>> rtl/core/dma_channel_block_and_list_engine.sv
// top level of the dma channel block and linked-list sequencer
//
//  channel   handshake          payload
//  -------   ----------------   -----------------------------------
//  item      push / full        item     (operation, data_word)
//  result    empty / pop        result   (kind, address, data_out, raise_irq, last)
//  config    cfg_valid / ready  cfg_index (3), cfg_data (24)
//
// a beat on item reaches the sequencer after acceptance through a
// two-entry command queue; the sequencer handles one command per cycle and
// writes up to two results into a four-entry result queue, first result
// visible the cycle after. the sequencer stalls while the result queue has
// fewer than two free entries; full rises only when the command queue fills.
// reset clears queues, sequencer state and configuration registers.
module dma_channel_block_and_list_engine #(
	parameter int RAM_ADDR_BITS = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  dcbl_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output dcbl_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [23:0]       cfg_data
);
	import dcbl_pkg::*;

	cfg_t       cfg_q;
	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_pop;
	logic       oq_room;
	result_t    res0;
	result_t    res1;
	logic [1:0] res_count;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BASE_ADDRESS: cfg_q.base_address <= cfg_data;
				CFG_WORD_COUNT:   cfg_q.word_count   <= cfg_data;
				CFG_STEP_DOWN:    cfg_q.step_down    <= cfg_data[0];
				CFG_TO_RAM:       cfg_q.to_ram       <= cfg_data[0];
				CFG_LIST_MODE:    cfg_q.list_mode    <= cfg_data[0];
				CFG_TABLE_CLEAR:  cfg_q.table_clear  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify
	dcbl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: channel sequencer
	dcbl_exec #(
		.RAM_ADDR_BITS (RAM_ADDR_BITS)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.room      (oq_room),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	// result queue
	dcbl_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr0      (res0),
		.wr1      (res1),
		.wr_count (res_count),
		.room     (oq_room),
		.empty    (empty),
		.pop      (pop),
		.head     (result)
	);

`ifndef SYNTH
	// sequencer only takes a command when the result queue can hold two results
	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (oq_room && cmd_valid))
		else $error("command taken without result queue room");

	// results appear only for a command taken in the same cycle
	a_res_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(res_count != 2'd0) |-> cmd_pop)
		else $error("result written without a command");

	// a pair of results: first one open, second one closes the beat
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_count == 2'd2) |-> (!res0.last && res1.last))
		else $error("bad last marking on a result pair");

	// a single result closes the beat
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_count == 2'd1) |-> res0.last)
		else $error("single result without last");

	// an accepted beat is waiting for the sequencer in the next cycle
	a_push_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> cmd_valid)
		else $error("accepted beat missing from command queue");
`endif

endmodule

>>> sim/dcbl_checker.sv
`timescale 1ns / 100ps
// checker for the dma channel sequencer: predicts result beats from item beats and compares
module dcbl_checker #(
	parameter int RAM_ADDR_BITS = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  dcbl_pkg::item_t   item,
	input  logic              empty,
	input  logic              pop,
	input  dcbl_pkg::result_t result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	output int                fail_count,
	output int                outstanding,
	output int                checked_count
);
	import dcbl_pkg::*;

	localparam logic [23:0] RAM_MASK  = 24'((1 << RAM_ADDR_BITS) - 1);
	localparam logic [23:0] WORD_MASK = RAM_MASK & ~24'd3;
	localparam logic [23:0] END_BIT   = 24'h800000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BLOCK_READ,
		ST_BLOCK_WRITE,
		ST_LIST_HEADER,
		ST_LIST_PACKET
	} walk_state_t;

	// shadow of the channel registers and sequencer state
	cfg_t        chan_cfg;
	walk_state_t walk;
	logic [23:0] cur_addr;
	logic [23:0] words_left;
	logic [7:0]  packet_left;
	logic [23:0] next_link;

	// result beats predicted but not yet seen, oldest first
	result_t     due_results[$];

	function automatic void owe(logic [2:0] kind, logic [23:0] addr, logic [31:0] data,
			logic irq, logic fin);
		result_t r;
		r.kind      = kind;
		r.address   = addr;
		r.data_out  = data;
		r.raise_irq = irq;
		r.last      = fin;
		due_results.push_back(r);
	endfunction

	function automatic logic [23:0] step_addr(logic [23:0] a);
		return chan_cfg.step_down ? a - 24'd4 : a + 24'd4;
	endfunction

	// end of a packet: chase the next header or finish the walk
	function automatic void follow_link();
		cur_addr = next_link;
		if ((next_link & END_BIT) != 0) begin
			owe(KIND_DONE, next_link, '0, next_link != END_MARKER, 1'b1);
			walk = ST_IDLE;
		end else begin
			owe(KIND_READ, next_link & WORD_MASK, '0, 1'b0, 1'b1);
			walk = ST_LIST_HEADER;
		end
	endfunction

	function automatic void predict_item(item_t it);
		logic [31:0] w;
		logic        fin;
		if (it.operation == OP_START) begin
			cur_addr    = chan_cfg.base_address;
			packet_left = '0;
			next_link   = '0;
			if (chan_cfg.list_mode) begin
				words_left = '0;
				if (chan_cfg.to_ram) begin
					owe(KIND_ERROR, chan_cfg.base_address, '0, 1'b0, 1'b1);
					walk = ST_IDLE;
				end else begin
					owe(KIND_READ, cur_addr & WORD_MASK, '0, 1'b0, 1'b1);
					walk = ST_LIST_HEADER;
				end
			end else begin
				words_left = chan_cfg.word_count;
				if (words_left == 0) begin
					owe(KIND_DONE, cur_addr, '0, 1'b0, 1'b1);
					walk = ST_IDLE;
				end else if (chan_cfg.to_ram) begin
					walk = ST_BLOCK_WRITE;
				end else begin
					owe(KIND_READ, cur_addr & WORD_MASK, '0, 1'b0, 1'b1);
					walk = ST_BLOCK_READ;
				end
			end
		end else begin
			case (walk)
				ST_BLOCK_READ: begin
					owe(KIND_DEVICE, '0, it.data_word, 1'b0, 1'b0);
					cur_addr   = step_addr(cur_addr);
					words_left = words_left - 24'd1;
					if (words_left == 0) begin
						owe(KIND_DONE, cur_addr, '0, 1'b0, 1'b1);
						walk = ST_IDLE;
					end else begin
						owe(KIND_READ, cur_addr & WORD_MASK, '0, 1'b0, 1'b1);
					end
				end
				ST_BLOCK_WRITE: begin
					// ordering table entries point one word back, last one is the end marker
					w = it.data_word;
					if (chan_cfg.table_clear)
						w = (words_left == 1) ? {8'h00, END_MARKER}
							: {8'h00, (cur_addr - 24'd4) & RAM_MASK};
					fin = (words_left != 1);
					owe(KIND_WRITE, cur_addr & WORD_MASK, w, 1'b0, fin);
					cur_addr   = step_addr(cur_addr);
					words_left = words_left - 24'd1;
					if (words_left == 0) begin
						owe(KIND_DONE, cur_addr, '0, 1'b0, 1'b1);
						walk = ST_IDLE;
					end
				end
				ST_LIST_HEADER: begin
					packet_left = it.data_word[31:24];
					next_link   = it.data_word[23:0];
					cur_addr    = cur_addr + 24'd4;
					if (packet_left == 0) begin
						follow_link();
					end else begin
						owe(KIND_READ, cur_addr & WORD_MASK, '0, 1'b0, 1'b1);
						walk = ST_LIST_PACKET;
					end
				end
				ST_LIST_PACKET: begin
					owe(KIND_DEVICE, '0, it.data_word, 1'b0, 1'b0);
					packet_left = packet_left - 8'd1;
					if (packet_left == 0) begin
						follow_link();
					end else begin
						cur_addr = cur_addr + 24'd4;
						owe(KIND_READ, cur_addr & WORD_MASK, '0, 1'b0, 1'b1);
					end
				end
				default: walk = ST_IDLE;
			endcase
		end
	endfunction

	function automatic void write_reg(logic [2:0] idx, logic [23:0] val);
		case (idx)
			CFG_BASE_ADDRESS: chan_cfg.base_address = val;
			CFG_WORD_COUNT:   chan_cfg.word_count   = val;
			CFG_STEP_DOWN:    chan_cfg.step_down    = val[0];
			CFG_TO_RAM:       chan_cfg.to_ram       = val[0];
			CFG_LIST_MODE:    chan_cfg.list_mode    = val[0];
			CFG_TABLE_CLEAR:  chan_cfg.table_clear  = val[0];
			default: ;
		endcase
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		if (due_results.size() == 0) begin
			$error("unexpected result beat: kind %0d address %h data_out %h",
				got.kind, got.address, got.data_out);
			fail_count++;
		end else begin
			want = due_results.pop_front();
			checked_count++;
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				fail_count++;
			end
			if (got.address !== want.address) begin
				$error("address: expected %h, got %h", want.address, got.address);
				fail_count++;
			end
			if (got.data_out !== want.data_out) begin
				$error("data_out: expected %h, got %h", want.data_out, got.data_out);
				fail_count++;
			end
			if (got.raise_irq !== want.raise_irq) begin
				$error("raise_irq: expected %0b, got %0b", want.raise_irq, got.raise_irq);
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				fail_count++;
			end
		end
	endfunction

	// compare before predicting: a beat popped now never belongs to an item pushed now
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cfg      = '0;
			walk          = ST_IDLE;
			cur_addr      = '0;
			words_left    = '0;
			packet_left   = '0;
			next_link     = '0;
			fail_count    = 0;
			checked_count = 0;
			due_results.delete();
			outstanding  <= 0;
		end else begin
			if (pop && !empty)
				check_result(result);
			if (cfg_valid && cfg_ready)
				write_reg(cfg_index, cfg_data);
			if (push && !full)
				predict_item(item);
			outstanding <= due_results.size();
		end
	end

endmodule

>>> sim/dma_channel_block_and_list_engine_tb.sv
`timescale 1ns / 100ps
// testbench top for the dma channel sequencer: clock, reset, stimulus and verdict
module dma_channel_block_and_list_engine_tb;
	import dcbl_pkg::*;

	localparam int       RAM_BITS      = 21;
	localparam int       NUM_ITEMS     = 1300;
	localparam int       IDLE_PCT      = 26;
	localparam int       STALL_LIMIT   = 1000;
	localparam int       SETTLE_CYCLES = 8;
	localparam int       DRAIN_CYCLES  = 16;
	localparam logic     OP_WORD       = ~OP_START;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	item_t       item      = '0;
	logic        empty;
	logic        pop       = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_BASE_ADDRESS;
	logic [23:0] cfg_data  = '0;

	int mismatches;
	int outstanding;
	int checked;
	int items_sent   = 0;
	int setups       = 0;
	int stall_cycles = 0;
	bit gaps_on      = 1'b1;

	dma_channel_block_and_list_engine #(
		.RAM_ADDR_BITS(RAM_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	dcbl_checker #(
		.RAM_ADDR_BITS(RAM_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.item         (item),
		.empty        (empty),
		.pop          (pop),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (mismatches),
		.outstanding  (outstanding),
		.checked_count(checked)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: random back-pressure unless in the quiet stretch
	always @(posedge clk) begin
		pop <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("dma_channel_block_and_list_engine regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// one item beat, with random gaps before it
	task automatic send(input logic op, input logic [31:0] word, input bit counted);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{operation: op, data_word: word};
		do @(posedge clk); while (full);
		if (counted)
			items_sent++;
	endtask

	// wait until every predicted beat is out and the command queue has drained
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic reconfigure(input cfg_t c);
		settle();
		put_reg(CFG_BASE_ADDRESS, c.base_address);
		put_reg(CFG_WORD_COUNT, c.word_count);
		put_reg(CFG_STEP_DOWN, {23'd0, c.step_down});
		put_reg(CFG_TO_RAM, {23'd0, c.to_ram});
		put_reg(CFG_LIST_MODE, {23'd0, c.list_mode});
		put_reg(CFG_TABLE_CLEAR, {23'd0, c.table_clear});
		cfg_valid <= 1'b0;
		setups++;
	endtask

	task automatic move_block(input int words);
		send(OP_START, $urandom(), 1'b1);
		repeat (words) send(OP_WORD, $urandom(), 1'b1);
	endtask

	// well-formed list walk with random packets; cut stops it early after that many words
	task automatic walk_list(input int hops, input int cut);
		int          count;
		int          sent;
		logic [23:0] link;
		sent = 0;
		send(OP_START, $urandom(), 1'b1);
		for (int h = 0; h < hops; h++) begin
			case ($urandom_range(19))
				0:       count = $urandom_range(21, 255);
				1, 2, 3: count = $urandom_range(5, 20);
				default: count = $urandom_range(0, 4);
			endcase
			if (h == hops - 1)
				link = $urandom_range(1) ? END_MARKER : (24'($urandom()) | 24'h800000);
			else
				link = 24'($urandom()) & 24'h7FFFFF;
			if (sent == cut)
				return;
			send(OP_WORD, {8'(count), link}, 1'b1);
			sent++;
			repeat (count) begin
				if (sent == cut)
					return;
				send(OP_WORD, $urandom(), 1'b1);
				sent++;
			end
		end
	endtask

	initial begin
		cfg_t c;
		int   words;
		int   hops;
		bit   finished;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings give an empty block, stray word while idle is dropped
		send(OP_WORD, 32'hFFFF_FFFF, 1'b0);
		send(OP_START, 32'h0000_0000, 1'b1);

		// read block climbing past the top of the address space
		reconfigure('{24'hFFFFFE, 24'd3, 1'b0, 1'b0, 1'b0, 1'b0});
		move_block(3);

		// write block stepping down through zero, restarted while busy
		reconfigure('{24'h000002, 24'hFFFFFF, 1'b1, 1'b1, 1'b0, 1'b0});
		move_block(2);
		move_block(1);

		// ordering table clear at the top of ram
		reconfigure('{24'h1FFFFC, 24'd3, 1'b1, 1'b1, 1'b0, 1'b1});
		move_block(3);

		// list walk toward ram is refused
		reconfigure('{24'hFFFFFF, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1});
		send(OP_START, 32'h0, 1'b1);

		// list walk: packet, empty packet, odd end marker, then a clean end
		reconfigure('{24'h000100, 24'd0, 1'b0, 1'b0, 1'b1, 1'b0});
		send(OP_START, 32'h0, 1'b1);
		send(OP_WORD, 32'h0200_0200, 1'b1);
		send(OP_WORD, 32'h1234_5678, 1'b1);
		send(OP_WORD, 32'h8765_4321, 1'b1);
		send(OP_WORD, 32'h0000_0300, 1'b1);
		send(OP_WORD, 32'h0081_2345, 1'b1);
		send(OP_START, 32'h0, 1'b1);
		send(OP_WORD, 32'h00FF_FFFF, 1'b1);

		// random phases, each under its own channel settings
		while (items_sent < NUM_ITEMS) begin
			gaps_on <= !(items_sent >= 500 && items_sent < 760);
			case ($urandom_range(7))
				0:       c.base_address = '0;
				1:       c.base_address = 24'hFFFFFF;
				2:       c.base_address = 24'hFFFFFC;
				default: c.base_address = 24'($urandom());
			endcase
			case ($urandom_range(19))
				0:       c.word_count = '0;
				1:       c.word_count = $urandom_range(1) ? 24'hFFFFFF : 24'($urandom());
				2, 3:    c.word_count = 24'($urandom_range(7, 40));
				default: c.word_count = 24'($urandom_range(1, 6));
			endcase
			c.step_down   = 1'($urandom_range(1));
			c.list_mode   = ($urandom_range(99) < 40);
			c.to_ram      = c.list_mode ? ($urandom_range(99) < 15) : 1'($urandom_range(1));
			c.table_clear = 1'($urandom_range(1));
			reconfigure(c);

			repeat ($urandom_range(1, 5)) begin
				finished = 1'b1;
				if (c.list_mode && c.to_ram) begin
					send(OP_START, $urandom(), 1'b1);
				end else if (c.list_mode) begin
					hops = $urandom_range(1, 4);
					if ($urandom_range(9) == 0) begin
						walk_list(hops, $urandom_range(0, 6));
						finished = 1'b0;
					end else begin
						walk_list(hops, -1);
					end
				end else begin
					words = int'(c.word_count);
					if (c.word_count > 40)
						words = $urandom_range(1, 10);
					else if (c.word_count != 0 && $urandom_range(9) == 0)
						words = $urandom_range(0, int'(c.word_count) - 1);
					finished = (words == int'(c.word_count));
					move_block(words);
				end
				if (finished && $urandom_range(19) == 0)
					send(OP_WORD, $urandom(), 1'b0);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d item beats over %0d channel setups, %0d result beats checked",
			items_sent, setups, checked);
		if (mismatches == 0 && outstanding == 0)
			$display("dma_channel_block_and_list_engine regression: pass");
		else
			$display("dma_channel_block_and_list_engine regression: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/dcbl_pkg.sv
rtl/core/dcbl_front.sv
rtl/core/dcbl_exec.sv
rtl/core/dcbl_outq.sv
rtl/core/dma_channel_block_and_list_engine.sv
sim/dcbl_checker.sv
sim/dma_channel_block_and_list_engine_tb.sv
